// File: rtl/segmented_record_rejoiner_core_macros.svh
// Assertion macros shared by the rejoiner RTL
`ifndef SEGMENTED_RECORD_REJOINER_CORE_MACROS_SVH
`define SEGMENTED_RECORD_REJOINER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/srr_pkg.sv
// Shared types and constants of the segmented record rejoiner
package srr_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] LIMIT_RESET = 16'd512;

    localparam logic [1:0] KIND_APPEND   = 2'd0;
    localparam logic [1:0] KIND_PATCH    = 2'd1;
    localparam logic [1:0] KIND_LEN_ERR  = 2'd2;
    localparam logic [1:0] KIND_CODE_ERR = 2'd3;

    localparam logic [1:0] SEG_CONT  = 2'd0;
    localparam logic [1:0] SEG_START = 2'd1;
    localparam logic [1:0] SEG_END   = 2'd2;
    localparam logic [1:0] SEG_WHOLE = 2'd3;

    typedef enum logic [2:0] {
        CMD_BYTE,
        CMD_WORD,
        CMD_WORD_PATCH,
        CMD_LEN_ERR,
        CMD_CODE_ERR
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [31:0] value;
        logic [31:0] offset;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/srr_front.sv
// Front end: parses segment headers and turns input bytes into commands
module srr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output logic          o_ready,
    input  logic          i_cfg_valid,
    input  logic [15:0]   i_cfg_data,
    input  srr_pkg::t_q_stat i_q_stat,
    output logic          o_push,
    output srr_pkg::t_cmd o_cmd
);
    import srr_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_TRAILER
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_halted, n_halted;
    logic [15:0] r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic [15:0] r_code, n_code;
    logic [15:0] r_body, n_body;
    logic [31:0] r_sum, n_sum;
    logic [31:0] r_start, n_start;
    logic [31:0] r_ocount, n_ocount;
    logic [15:0] r_limit, n_limit;

    logic        w_fire;
    logic        w_len_bad;
    logic [15:0] w_code;
    logic [15:0] w_body_hdr;

    assign o_ready    = !i_q_stat.full;
    assign w_fire     = i_valid && o_ready;
    assign w_len_bad  = (r_len < 32'd2) || (({1'b0, r_len} + 33'd2) > {17'd0, r_limit});
    assign w_code     = {i_byte, r_code[7:0]};
    assign w_body_hdr = r_len[15:0] - 16'd2;

    always_comb begin
        n_phase  = r_phase;
        n_halted = r_halted;
        n_pos    = r_pos;
        n_len    = r_len;
        n_code   = r_code;
        n_body   = r_body;
        n_sum    = r_sum;
        n_start  = r_start;
        n_ocount = r_ocount;
        n_limit  = r_limit;
        o_push   = 1'b0;
        o_cmd    = '{op: CMD_BYTE, value: 32'd0, offset: 32'd0};
        if (i_cfg_valid) begin
            n_limit = i_cfg_data;
        end
        if (w_fire && !r_halted) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos < 16'd4) begin
                        n_len[8*r_pos[1:0] +: 8] = i_byte;
                        n_pos = r_pos + 16'd1;
                    end else if (r_pos == 16'd4) begin
                        n_code[7:0] = i_byte;
                        n_pos = r_pos + 16'd1;
                    end else begin
                        n_pos  = 16'd0;
                        n_code = w_code;
                        if (w_len_bad) begin
                            o_push   = 1'b1;
                            o_cmd.op = CMD_LEN_ERR;
                            n_halted = 1'b1;
                        end else if (w_code > 16'd3) begin
                            o_push   = 1'b1;
                            o_cmd.op = CMD_CODE_ERR;
                            n_halted = 1'b1;
                        end else begin
                            n_body = w_body_hdr;
                            case (w_code[1:0])
                                SEG_START: begin
                                    n_start     = r_ocount;
                                    n_sum       = {16'd0, w_body_hdr};
                                    o_push      = 1'b1;
                                    o_cmd.op    = CMD_WORD;
                                    o_cmd.value = {16'd0, w_body_hdr};
                                    n_ocount    = r_ocount + 32'd4;
                                end
                                SEG_WHOLE: begin
                                    n_sum       = {16'd0, w_body_hdr};
                                    o_push      = 1'b1;
                                    o_cmd.op    = CMD_WORD;
                                    o_cmd.value = {16'd0, w_body_hdr};
                                    n_ocount    = r_ocount + 32'd4;
                                end
                                default: begin
                                    n_sum = r_sum + {16'd0, w_body_hdr};
                                end
                            endcase
                            n_phase = (w_body_hdr != 16'd0) ? PH_BODY : PH_TRAILER;
                        end
                    end
                end
                PH_BODY: begin
                    o_push      = 1'b1;
                    o_cmd.op    = CMD_BYTE;
                    o_cmd.value = {24'd0, i_byte};
                    n_ocount    = r_ocount + 32'd1;
                    if (({1'b0, r_pos} + 17'd1) >= {1'b0, r_body}) begin
                        n_phase = PH_TRAILER;
                        n_pos   = 16'd0;
                    end else begin
                        n_pos = r_pos + 16'd1;
                    end
                end
                PH_TRAILER: begin
                    if (r_pos == 16'd3) begin
                        n_phase = PH_HEADER;
                        n_pos   = 16'd0;
                        if (r_code[1:0] == SEG_END) begin
                            o_push       = 1'b1;
                            o_cmd.op     = CMD_WORD_PATCH;
                            o_cmd.value  = r_sum;
                            o_cmd.offset = r_start;
                            n_ocount     = r_ocount + 32'd4;
                        end else if (r_code[1:0] == SEG_WHOLE) begin
                            o_push      = 1'b1;
                            o_cmd.op    = CMD_WORD;
                            o_cmd.value = r_sum;
                            n_ocount    = r_ocount + 32'd4;
                        end
                    end else begin
                        n_pos = r_pos + 16'd1;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_halted <= 1'b0;
            r_pos    <= 16'd0;
            r_len    <= 32'd0;
            r_code   <= 16'd0;
            r_body   <= 16'd0;
            r_sum    <= 32'd0;
            r_start  <= 32'd0;
            r_ocount <= 32'd0;
            r_limit  <= LIMIT_RESET;
        end else begin
            r_phase  <= n_phase;
            r_halted <= n_halted;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_code   <= n_code;
            r_body   <= n_body;
            r_sum    <= n_sum;
            r_start  <= n_start;
            r_ocount <= n_ocount;
            r_limit  <= n_limit;
        end
    end

endmodule

// File: rtl/srr_cmd_fifo.sv
// Command queue between front end and result generator
module srr_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  srr_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output srr_pkg::t_cmd    o_head,
    output srr_pkg::t_q_stat o_stat
);
    import srr_pkg::*;
    `include "segmented_record_rejoiner_core_macros.svh"

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SRR_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_stat.full, "push into full queue")
    `SRR_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_stat.empty, "pop from empty queue")
    `SRR_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, (i_push && !i_pop), (r_count != '0), "count lost a push")

endmodule

// File: rtl/srr_back.sv
// Back end: expands queued commands into result transactions
module srr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srr_pkg::t_cmd    i_head,
    input  srr_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [71:0]      o_data,
    output logic [1:0]       o_user,
    output logic             o_last
);
    import srr_pkg::*;
    `include "segmented_record_rejoiner_core_macros.svh"

    logic        r_busy;
    t_cmd        r_cmd;
    logic [2:0]  r_step;
    logic        r_out_valid;
    logic [71:0] r_data;
    logic [1:0]  r_user;
    logic        r_last;

    t_cmd        w_act;
    logic        w_act_valid;
    logic [2:0]  w_step;
    logic        w_load;
    logic        w_fire;
    logic        w_final;
    logic [7:0]  w_byte;
    logic [31:0] w_off;
    logic [31:0] w_val;
    logic [1:0]  w_kind;

    assign w_act       = r_busy ? r_cmd : i_head;
    assign w_act_valid = r_busy || !i_q_stat.empty;
    assign w_step      = r_busy ? r_step : 3'd0;
    assign w_load      = !r_out_valid || i_ready;
    assign w_fire      = w_load && w_act_valid;
    assign o_pop       = w_fire && !r_busy;

    always_comb begin
        w_kind  = KIND_APPEND;
        w_byte  = 8'd0;
        w_off   = 32'd0;
        w_val   = 32'd0;
        w_final = 1'b1;
        unique case (w_act.op)
            CMD_BYTE: begin
                w_byte = w_act.value[7:0];
            end
            CMD_WORD: begin
                w_byte  = w_act.value[8*w_step[1:0] +: 8];
                w_final = (w_step == 3'd3);
            end
            CMD_WORD_PATCH: begin
                if (w_step == 3'd4) begin
                    w_kind = KIND_PATCH;
                    w_off  = w_act.offset;
                    w_val  = w_act.value;
                end else begin
                    w_byte  = w_act.value[8*w_step[1:0] +: 8];
                    w_final = 1'b0;
                end
            end
            CMD_LEN_ERR: begin
                w_kind = KIND_LEN_ERR;
            end
            CMD_CODE_ERR: begin
                w_kind = KIND_CODE_ERR;
            end
            default: begin
                w_kind = KIND_APPEND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= w_act_valid;
            end
            if (w_fire) begin
                if (w_final) begin
                    r_busy <= 1'b0;
                    r_step <= 3'd0;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= w_step + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_cmd  <= w_act;
            r_data <= {w_val, w_off, w_byte};
            r_user <= w_kind;
            r_last <= w_final;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

    `SRR_ASSERT_NOW(a_busy_step, i_clk, i_rst_n, r_busy, (r_step != 3'd0), "busy with step zero")
    `SRR_ASSERT_NOW(a_word_step, i_clk, i_rst_n, (r_busy && r_cmd.op == CMD_WORD), (r_step <= 3'd3), "word step overrun")
    `SRR_ASSERT_NEXT(a_busy_out, i_clk, i_rst_n, (w_fire && !w_final), o_valid, "expansion without result")

endmodule

// File: rtl/segmented_record_rejoiner_core.sv
// A byte's command is queued, then registered in the output stage before results are offered.
// Throughput: one input byte per cycle while the command queue is not full; one result per
// cycle while i_m_tready is high, set by the output stage. Length words and patched closing
// words expand into result bursts; a 4-entry queue between parser and output stage absorbs them.
// Reset: synchronous active-low; clears parser state, queue, output and sets limit to 512.
module segmented_record_rejoiner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [7:0] out_byte, [39:8] patch_offset, [71:40] patch_value
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data   // [15:0] buffer_limit
);
    import srr_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_cmd    w_cmd;
    t_cmd    w_head;
    t_q_stat w_q_stat;

    assign o_cfg_ready = 1'b1;

    srr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_byte      (i_s_tdata),
        .o_ready     (o_s_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_cmd       (w_cmd)
    );

    srr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    srr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_data   (o_m_tdata),
        .o_user   (o_m_tuser),
        .o_last   (o_m_tlast)
    );

endmodule
